// File: rtl/core/cnms_pkg.sv
// ----------------------------------------------------------------------------
// cnms_pkg
// Shared types and constants for the cross-neighbour morphology stencil.
// ----------------------------------------------------------------------------
package cnms_pkg;

    localparam int unsigned MAX_COLS_DEF = 256;
    localparam int unsigned MAX_ROWS_DEF = 256;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned GEOM_W    = 9;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 9;
    localparam int unsigned IDX_OUT_W = 8;

    localparam logic [GEOM_W-1:0] COLS_RST  = 9'd256;
    localparam logic [GEOM_W-1:0] ROWS_RST  = 9'd256;
    localparam logic              MODE_RST  = 1'b0;
    localparam logic [PIX_W-1:0]  MATCH_RST = 8'd88;
    localparam logic [PIX_W-1:0]  WRITE_RST = 8'd88;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS  = 3'd0,
        CFG_ROWS  = 3'd1,
        CFG_MODE  = 3'd2,
        CFG_MATCH = 3'd3,
        CFG_WRITE = 3'd4
    } t_cfg_idx;

    // Input item kinds
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // Combine modes
    typedef enum logic {
        MODE_ANY = 1'b0,
        MODE_ALL = 1'b1
    } t_mode;

    // Frame border position of one output pixel
    typedef struct packed {
        logic top;
        logic bot;
        logic lft;
        logic rgt;
    } t_edge;

    // Saturate a geometry register to [2, maxv] and return the value minus one.
    function automatic logic [31:0] geom_m1(logic [GEOM_W-1:0] v, int unsigned maxv);
        logic [31:0] ext;
        logic [31:0] res;
        ext = 32'(v);
        if (ext < 32'd2) begin
            res = 32'd1;
        end else if (ext > maxv) begin
            res = maxv - 32'd1;
        end else begin
            res = ext - 32'd1;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/cnms_ram.sv
// ----------------------------------------------------------------------------
// cnms_ram
// Generic RAM: one write port, two read ports, registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module cnms_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// File: rtl/core/cross_neighbour_morphology_stencil.sv
// ----------------------------------------------------------------------------
// cross_neighbour_morphology_stencil
// 3x3 cross binary morphology (dilate / erode / outline) on a raster stream
// of character pixels, with a two-row circular line store.
// ----------------------------------------------------------------------------
// Result path: the beat that carries pixel k+cols (or the matching drain
//   beat) loads stage 2 for pixel k; the output register follows it.
// Throughput: one input beat per cycle while the output is not stalled, set
//   by the line store RAM (two read ports, one write port).
// Reset: synchronous, active low; clears positions and loads register
//   defaults. The line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module cross_neighbour_morphology_stencil
    import cnms_pkg::*;
#(
    parameter int unsigned MAX_COLS = MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_op,
    input  logic [PIX_W-1:0]     i_pixel_in,
    // output channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PIX_W-1:0]     o_pixel_out,
    output logic [IDX_OUT_W-1:0] o_row_index,
    output logic [IDX_OUT_W-1:0] o_col_index,
    output logic                 o_frame_last
);

    localparam int unsigned COL_W = $clog2(MAX_COLS);
    localparam int unsigned ROW_W = $clog2(MAX_ROWS);
    localparam int unsigned AW    = COL_W + 1;     // two rows of storage
    localparam int unsigned DEPTH = 2 * MAX_COLS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GEOM_W-1:0] r_cfg_cols;
    logic [GEOM_W-1:0] r_cfg_rows;
    logic              r_cfg_mode;
    logic [PIX_W-1:0]  r_cfg_match;
    logic [PIX_W-1:0]  r_cfg_write;

    logic cfg_acc;
    logic geom_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign geom_wr     = cfg_acc && ((i_cfg_index == CFG_COLS) || (i_cfg_index == CFG_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols  <= COLS_RST;
            r_cfg_rows  <= ROWS_RST;
            r_cfg_mode  <= MODE_RST;
            r_cfg_match <= MATCH_RST;
            r_cfg_write <= WRITE_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_COLS:  r_cfg_cols  <= i_cfg_data;
                CFG_ROWS:  r_cfg_rows  <= i_cfg_data;
                CFG_MODE:  r_cfg_mode  <= i_cfg_data[0];
                CFG_MATCH: r_cfg_match <= i_cfg_data[PIX_W-1:0];
                CFG_WRITE: r_cfg_write <= i_cfg_data[PIX_W-1:0];
                default: begin
                    // indexes past the list are dropped
                end
            endcase
        end
    end

    // Saturated geometry, held as size minus one
    logic [31:0]      cols_m1_full;
    logic [31:0]      rows_m1_full;
    logic [COL_W-1:0] cols_m1;
    logic [ROW_W-1:0] rows_m1;
    logic [AW-1:0]    addr_top;     // 2*cols - 1, last slot of the ring

    assign cols_m1_full = geom_m1(r_cfg_cols, MAX_COLS);
    assign rows_m1_full = geom_m1(r_cfg_rows, MAX_ROWS);
    assign cols_m1      = cols_m1_full[COL_W-1:0];
    assign rows_m1      = rows_m1_full[ROW_W-1:0];
    assign addr_top     = {cols_m1, 1'b1};

    // ------------------------------------------------------------------
    // Frame position state
    //   in_row/in_col : position of the next pixel to arrive
    //   out_row/out_col : position of the next pixel to emit
    //   wa : ring slot of the next write; also the slot of the pixel one row
    //        above the pixel being emitted (read before it is overwritten)
    //   ra : ring slot of the pixel right of the pixel being emitted
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic             r_in_done, n_in_done;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [AW-1:0]    r_wa,      n_wa;
    logic [AW-1:0]    r_ra,      n_ra;

    logic in_acc;
    logic is_pix;
    logic is_drn;
    logic pix_emit;
    logic emit;
    logic rd_ev;
    logic in_last_col;
    logic in_last_row;
    logic out_last_col;
    logic out_last;
    logic frame_end;

    // Stage 2 (RAM data valid) and output register
    logic                 r_s2_valid, n_s2_valid;
    logic [PIX_W-1:0]     r_s2_down;
    t_edge                r_s2_edge;
    logic [IDX_OUT_W-1:0] r_s2_row;
    logic [IDX_OUT_W-1:0] r_s2_col;
    logic                 r_s2_last;
    logic                 s2_adv;
    logic                 out_free;

    assign out_free = !o_valid || i_ready;
    assign s2_adv   = r_s2_valid && out_free;
    assign o_ready  = !r_s2_valid || out_free;

    always_comb begin
        in_acc       = i_valid && o_ready;
        is_pix       = in_acc && (i_op == OP_PIXEL) && !r_in_done;
        is_drn       = in_acc && (i_op == OP_DRAIN) && r_in_done;
        in_last_col  = (r_in_col == cols_m1);
        in_last_row  = (r_in_row == rows_m1);
        out_last_col = (r_out_col == cols_m1);
        out_last     = out_last_col && (r_out_row == rows_m1);
        pix_emit     = is_pix && (r_in_row != '0);
        emit         = pix_emit || is_drn;
        // the right-neighbour read runs one item ahead of the first emit
        rd_ev        = (is_pix && ((r_in_row != '0) || in_last_col)) || is_drn;
        frame_end    = is_drn && out_last;
    end

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_in_done = r_in_done;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_wa      = r_wa;
        n_ra      = r_ra;

        if (is_pix) begin
            if (in_last_col) begin
                n_in_col = '0;
                if (in_last_row) begin
                    n_in_done = 1'b1;
                end else begin
                    n_in_row = r_in_row + 1'b1;
                end
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
        end

        // advance the write slot on every counted item, drain included
        if (is_pix || is_drn) begin
            n_wa = (r_wa == addr_top) ? '0 : r_wa + 1'b1;
        end

        if (rd_ev) begin
            n_ra = (r_ra == addr_top) ? '0 : r_ra + 1'b1;
        end

        if (emit) begin
            if (out_last_col) begin
                n_out_col = '0;
                n_out_row = r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end

        // frame done or geometry changed: restart at the top left
        if (frame_end || geom_wr) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_in_done = 1'b0;
            n_out_row = '0;
            n_out_col = '0;
            n_wa      = '0;
            n_ra      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_in_done <= 1'b0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_wa      <= '0;
            r_ra      <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_in_done <= n_in_done;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_wa      <= n_wa;
            r_ra      <= n_ra;
        end
    end

    // ------------------------------------------------------------------
    // Line store: write the arriving pixel, read up (port B, old data at
    // the slot being overwritten) and right (port A) in the same cycle.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] ram_right;
    logic [PIX_W-1:0] ram_up;

    cnms_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_we      (is_pix),
        .i_waddr   (r_wa),
        .i_wdata   (i_pixel_in),
        .i_re      (rd_ev),
        .i_raddr_a (r_ra),
        .i_raddr_b (r_wa),
        .o_rdata_a (ram_right),
        .o_rdata_b (ram_up)
    );

    // Middle-row window: shift the previous right read into centre, centre
    // into left, on each read. The item in stage 2 always leaves at that edge.
    logic [PIX_W-1:0] r_win_l;
    logic [PIX_W-1:0] r_win_c;

    always_ff @(posedge i_clk) begin
        if (rd_ev) begin
            r_win_l <= r_win_c;
            r_win_c <= ram_right;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 load: hold position, border flags and the pixel below
    // ------------------------------------------------------------------
    logic [31:0] out_row_ext;
    logic [31:0] out_col_ext;

    assign out_row_ext = 32'(r_out_row);
    assign out_col_ext = 32'(r_out_col);

    always_comb begin
        if (in_acc) begin
            n_s2_valid = emit;
        end else begin
            n_s2_valid = r_s2_valid && !s2_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s2_down     <= i_pixel_in;
            r_s2_edge.top <= (r_out_row == '0);
            r_s2_edge.bot <= (r_out_row == rows_m1);
            r_s2_edge.lft <= (r_out_col == '0);
            r_s2_edge.rgt <= out_last_col;
            r_s2_row      <= out_row_ext[IDX_OUT_W-1:0];
            r_s2_col      <= out_col_ext[IDX_OUT_W-1:0];
            r_s2_last     <= out_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 compute: pick neighbours by border, combine, select result
    // ------------------------------------------------------------------
    logic             use_up, use_dn, use_lf, use_rt;
    logic             hit_up, hit_dn, hit_lf, hit_rt;
    logic             fire;
    logic [PIX_W-1:0] result;
    logic             vedge, hedge;

    always_comb begin
        vedge = r_s2_edge.top || r_s2_edge.bot;
        hedge = r_s2_edge.lft || r_s2_edge.rgt;
        priority if (vedge && hedge) begin
            // corner: one vertical and one horizontal neighbour inside
            use_up = r_s2_edge.bot;
            use_dn = r_s2_edge.top;
            use_lf = r_s2_edge.rgt;
            use_rt = r_s2_edge.lft;
        end else if (vedge) begin
            use_up = 1'b0;
            use_dn = 1'b0;
            use_lf = 1'b1;
            use_rt = 1'b1;
        end else if (hedge) begin
            use_up = 1'b1;
            use_dn = 1'b1;
            use_lf = 1'b0;
            use_rt = 1'b0;
        end else begin
            use_up = 1'b1;
            use_dn = 1'b1;
            use_lf = 1'b1;
            use_rt = 1'b1;
        end

        hit_up = (ram_up    == r_cfg_match);
        hit_dn = (r_s2_down == r_cfg_match);
        hit_lf = (r_win_l   == r_cfg_match);
        hit_rt = (ram_right == r_cfg_match);

        unique case (r_cfg_mode)
            MODE_ALL: fire = (!use_up || hit_up) && (!use_dn || hit_dn)
                          && (!use_lf || hit_lf) && (!use_rt || hit_rt);
            MODE_ANY: fire = (use_up && hit_up) || (use_dn && hit_dn)
                          || (use_lf && hit_lf) || (use_rt && hit_rt);
            default:  fire = 1'b0;
        endcase

        result = fire ? r_cfg_write : r_win_c;
    end

    // ------------------------------------------------------------------
    // Output register: takes stage 2 whenever it is empty or being drained
    // ------------------------------------------------------------------
    logic r_out_valid, n_out_valid;

    always_comb begin
        if (s2_adv) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            o_pixel_out  <= result;
            o_row_index  <= r_s2_row;
            o_col_index  <= r_s2_col;
            o_frame_last <= r_s2_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: dv/cnms_checker.sv
// ----------------------------------------------------------------------------
// cnms_checker
// Watches the configuration, pixel and result channels of the stencil,
// predicts each emitted pixel from its own copy of the registers, positions
// and two-row line store, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module cnms_checker
    import cnms_pkg::*;
#(
    parameter int unsigned MAX_COLS = MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_op,
    input  logic [PIX_W-1:0]     i_pixel_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [PIX_W-1:0]     i_pixel_out,
    input  logic [IDX_OUT_W-1:0] i_row_index,
    input  logic [IDX_OUT_W-1:0] i_col_index,
    input  logic                 i_frame_last,
    output int                   o_fail_count,
    output int                   o_waiting
);

    localparam int unsigned STORE_DEPTH = 2 * MAX_COLS;
    localparam int unsigned PEND_DEPTH  = 16;   // far above what the block holds

    typedef struct packed {
        logic [PIX_W-1:0]     pixel;
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
        logic                 last;
    } t_pixel_result;

    logic [GEOM_W-1:0] cols_reg;
    logic [GEOM_W-1:0] rows_reg;
    t_mode             mode_reg;
    logic [PIX_W-1:0]  match_reg;
    logic [PIX_W-1:0]  write_reg;

    logic [PIX_W-1:0]  line_buf [STORE_DEPTH];
    int unsigned       rx_count;    // pixels of the frame taken in
    int unsigned       tx_count;    // pixels of the frame emitted
    t_pixel_result     pending_pixels [PEND_DEPTH];
    int unsigned       pend_head;
    int unsigned       pend_count;
    int                mismatches = 0;
    int                waiting = 0;

    assign o_fail_count = mismatches;
    assign o_waiting    = waiting;

    function automatic int unsigned sat_dim(logic [GEOM_W-1:0] raw, int unsigned limit);
        if (raw < 2) return 2;
        if (raw > limit) return limit;
        return int'(raw);
    endfunction

    // Pixel at frame position p; the beat in flight sits at rx_count.
    function automatic logic [PIX_W-1:0] peek_frame(int unsigned p, bit cur_ok,
                                                    logic [PIX_W-1:0] cur_val,
                                                    int unsigned cols);
        if (cur_ok && p == rx_count) return cur_val;
        return line_buf[(p % (2 * cols)) % STORE_DEPTH];
    endfunction

    function automatic t_pixel_result stencil_result(bit cur_ok, logic [PIX_W-1:0] cur_val);
        int unsigned   cols, rows, k, r, c, seen, hits;
        bit            top, bot, lft, rgt, up, dn, lf, rt;
        logic [PIX_W-1:0] centre;
        t_pixel_result res;
        cols = sat_dim(cols_reg, MAX_COLS);
        rows = sat_dim(rows_reg, MAX_ROWS);
        k    = tx_count;
        r    = k / cols;
        c    = k % cols;
        top  = (r == 0);
        bot  = (r == rows - 1);
        lft  = (c == 0);
        rgt  = (c == cols - 1);
        // corners look at the one vertical and one horizontal neighbour inside
        if ((top || bot) && (lft || rgt)) begin
            up = bot; dn = top; lf = rgt; rt = lft;
        end else if (top || bot) begin
            up = 0; dn = 0; lf = 1; rt = 1;
        end else if (lft || rgt) begin
            up = 1; dn = 1; lf = 0; rt = 0;
        end else begin
            up = 1; dn = 1; lf = 1; rt = 1;
        end
        seen = 0;
        hits = 0;
        if (up) begin
            seen++;
            if (peek_frame(k - cols, cur_ok, cur_val, cols) == match_reg) hits++;
        end
        if (dn) begin
            seen++;
            if (peek_frame(k + cols, cur_ok, cur_val, cols) == match_reg) hits++;
        end
        if (lf) begin
            seen++;
            if (peek_frame(k - 1, cur_ok, cur_val, cols) == match_reg) hits++;
        end
        if (rt) begin
            seen++;
            if (peek_frame(k + 1, cur_ok, cur_val, cols) == match_reg) hits++;
        end
        centre = peek_frame(k, cur_ok, cur_val, cols);
        if (mode_reg == MODE_ALL) begin
            res.pixel = (hits == seen) ? write_reg : centre;
        end else begin
            res.pixel = (hits != 0) ? write_reg : centre;
        end
        res.row  = IDX_OUT_W'(r);
        res.col  = IDX_OUT_W'(c);
        res.last = (k == cols * rows - 1);
        return res;
    endfunction

    // Append one predicted pixel behind the ones still owed by the block.
    task automatic queue_result(t_pixel_result item);
        if (pend_count == PEND_DEPTH) begin
            $error("prediction buffer overflow: %0d results outstanding", pend_count);
            mismatches++;
        end else begin
            pending_pixels[(pend_head + pend_count) % PEND_DEPTH] = item;
            pend_count++;
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_result want;
        int unsigned   cols, rows;
        if (!i_rst_n) begin
            cols_reg   = COLS_RST;
            rows_reg   = ROWS_RST;
            mode_reg   = t_mode'(MODE_RST);
            match_reg  = MATCH_RST;
            write_reg  = WRITE_RST;
            rx_count   = 0;
            tx_count   = 0;
            foreach (line_buf[i]) line_buf[i] = '0;
            pend_head  = 0;
            pend_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COLS: begin
                        cols_reg = i_cfg_data;
                        rx_count = 0;
                        tx_count = 0;
                    end
                    CFG_ROWS: begin
                        rows_reg = i_cfg_data;
                        rx_count = 0;
                        tx_count = 0;
                    end
                    CFG_MODE:  mode_reg  = t_mode'(i_cfg_data[0]);
                    CFG_MATCH: match_reg = i_cfg_data[PIX_W-1:0];
                    CFG_WRITE: write_reg = i_cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                cols = sat_dim(cols_reg, MAX_COLS);
                rows = sat_dim(rows_reg, MAX_ROWS);
                if (i_op == OP_PIXEL) begin
                    // excess pixels past the frame end are dropped
                    if (rx_count < cols * rows) begin
                        if (rx_count >= cols) begin
                            queue_result(stencil_result(1'b1, i_pixel_in));
                            tx_count++;
                        end
                        line_buf[(rx_count % (2 * cols)) % STORE_DEPTH] = i_pixel_in;
                        rx_count++;
                    end
                end else if (rx_count >= cols * rows && tx_count < cols * rows) begin
                    queue_result(stencil_result(1'b0, '0));
                    tx_count++;
                    if (tx_count >= cols * rows) begin
                        rx_count = 0;
                        tx_count = 0;
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (pend_count == 0) begin
                    $error("unexpected result: pixel_out %0d row %0d col %0d",
                           i_pixel_out, i_row_index, i_col_index);
                    mismatches++;
                end else begin
                    want       = pending_pixels[pend_head];
                    pend_head  = (pend_head + 1) % PEND_DEPTH;
                    pend_count--;
                    check_field("pixel_out", 16'(want.pixel), 16'(i_pixel_out));
                    check_field("row_index", 16'(want.row), 16'(i_row_index));
                    check_field("col_index", 16'(want.col), 16'(i_col_index));
                    check_field("frame_last", 16'(want.last), 16'(i_frame_last));
                end
            end
        end
        waiting = int'(pend_count);
    end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the cross-neighbour morphology stencil with directed 3x3 frames and
// then with random frames of random size, rule and content, under random
// idling on both channels, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb
    import cnms_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT      = 1000000;
    localparam int unsigned SETTLE_CYCLES    = 8;     // output pipe depth plus margin
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned RANDOM_BEATS     = 700;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_op;
    logic [PIX_W-1:0]     i_pixel_in;
    logic                 o_valid;
    logic                 i_ready;
    logic [PIX_W-1:0]     o_pixel_out;
    logic [IDX_OUT_W-1:0] o_row_index;
    logic [IDX_OUT_W-1:0] o_col_index;
    logic                 o_frame_last;

    int                   fail_count;
    int                   waiting;

    // Stimulus-side view of the block setup, used to shape whole frames
    int unsigned          geo_cols;
    int unsigned          geo_rows;
    logic [PIX_W-1:0]     cur_match;
    logic [PIX_W-1:0]     cur_write;
    int unsigned          frame_beats;    // frame pixels and drain beats sent
    bit                   quiet;          // no idling on either side
    bit                   long_hold_req;  // ask the receiver for a long hold-off
    int unsigned          hold_at;        // frame pixel that raises the long hold-off
    int unsigned          cycle_count;

    cross_neighbour_morphology_stencil u_dut (.*);

    cnms_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_op         (i_op),
        .i_pixel_in   (i_pixel_in),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_pixel_out  (o_pixel_out),
        .i_row_index  (o_row_index),
        .i_col_index  (o_col_index),
        .i_frame_last (o_frame_last),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle length in cycles: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned clamp_dim(logic [GEOM_W-1:0] raw, int unsigned limit);
        if (raw < 2) return 2;
        if (raw > limit) return limit;
        return int'(raw);
    endfunction

    // Bias the content toward the match and write values so the rule fires
    // often in both modes, but keep the whole byte range in play.
    function automatic logic [PIX_W-1:0] frame_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return cur_match;
        if (roll < 55) return cur_write;
        if (roll < 65) return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
        return 8'($urandom);
    endfunction

    // Offer one beat after a random gap and hold it until it is taken.
    task automatic send_beat(t_op op, logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid, wait for every predicted pixel, then let the pipe settle.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COLS:  geo_cols  = clamp_dim(data, MAX_COLS_DEF);
            CFG_ROWS:  geo_rows  = clamp_dim(data, MAX_ROWS_DEF);
            CFG_MATCH: cur_match = data[PIX_W-1:0];
            CFG_WRITE: cur_write = data[PIX_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(logic [GEOM_W-1:0] cols, logic [GEOM_W-1:0] rows);
        cfg_write(CFG_COLS, cols);
        cfg_write(CFG_ROWS, rows);
    endtask

    task automatic pick_small_geometry();
        logic [GEOM_W-1:0] cols;
        logic [GEOM_W-1:0] rows;
        // raw 0 and 1 saturate up to two
        cols = ($urandom_range(0, 9) == 0) ? GEOM_W'($urandom_range(0, 1))
                                           : GEOM_W'($urandom_range(2, 9));
        rows = ($urandom_range(0, 9) == 0) ? GEOM_W'($urandom_range(0, 1))
                                           : GEOM_W'($urandom_range(2, 6));
        set_geometry(cols, rows);
    endtask

    task automatic set_rule();
        cfg_write(CFG_MODE, CFG_DAT_W'($urandom_range(0, 1)));
        cfg_write(CFG_MATCH, CFG_DAT_W'($urandom_range(0, 255)));
        // write equal to match gives a plain dilation or erosion
        cfg_write(CFG_WRITE, ($urandom_range(0, 2) == 0) ? CFG_DAT_W'(cur_match)
                                                         : CFG_DAT_W'($urandom_range(0, 255)));
    endtask

    // Send one frame in raster order and drain it. Stop early at cut_at to
    // leave the frame abandoned; change the rule before pixel rule_at.
    task automatic run_frame(bit noisy, int unsigned cut_at, int unsigned rule_at);
        int unsigned total;
        int unsigned n;
        total = geo_cols * geo_rows;
        for (n = 0; n < total; n++) begin
            if (n == cut_at) return;
            if (n == rule_at) begin
                wait_drained();
                set_rule();
            end
            // results are flowing by now: hold the receiver off while we keep sending
            if (n == hold_at) long_hold_req = 1'b1;
            // drain ahead of the frame end: ignored by the block
            if (noisy && $urandom_range(0, 19) == 0) send_beat(OP_DRAIN, 8'($urandom));
            send_beat(OP_PIXEL, frame_value());
            frame_beats++;
        end
        for (n = 0; n < geo_cols; n++) begin
            // pixel past the frame end: ignored until the drain completes
            if (noisy && $urandom_range(0, 9) == 0) send_beat(OP_PIXEL, 8'($urandom));
            send_beat(OP_DRAIN, 8'($urandom));
            frame_beats++;
        end
        // stray drain on the fresh frame
        if (noisy && $urandom_range(0, 9) == 0) send_beat(OP_DRAIN, 8'($urandom));
    endtask

    // Result side: random hold-offs, plus one long hold on request so the
    // pipe fills and the block pushes back on its input.
    initial begin
        int unsigned low;
        i_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                low = pick_gap();
                if (low != 0) begin
                    i_ready <= 1'b0;
                    repeat (low) @(negedge i_clk);
                end
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[cross_neighbour_morphology_stencil] ERROR");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned total;
        int unsigned cut;
        int unsigned rule_at;
        bit          regeometry;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_COLS;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_op          = OP_PIXEL;
        i_pixel_in    = '0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        hold_at       = '1;
        frame_beats   = 0;
        geo_cols      = clamp_dim(COLS_RST, MAX_COLS_DEF);
        geo_rows      = clamp_dim(ROWS_RST, MAX_ROWS_DEF);
        cur_match     = MATCH_RST;
        cur_write     = WRITE_RST;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 3x3 frame in any-mode covers corners, edges and the centre
        set_geometry(9'd3, 9'd3);
        cfg_write(CFG_MODE, CFG_DAT_W'(MODE_ANY));
        cfg_write(CFG_MATCH, 9'd88);
        cfg_write(CFG_WRITE, 9'd42);
        send_beat(OP_DRAIN, 8'hA5);      // drain before any pixel: dropped
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd0);
        send_beat(OP_PIXEL, 8'd255);
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd7);
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd255);
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd0);
        send_beat(OP_DRAIN, 8'h00);
        send_beat(OP_PIXEL, 8'd1);       // frame already complete: dropped
        send_beat(OP_DRAIN, 8'hFF);
        send_beat(OP_DRAIN, 8'h5A);

        // Directed: all-mode, erosion-like ring around a hole
        wait_drained();
        cfg_write(CFG_MODE, CFG_DAT_W'(MODE_ALL));
        cfg_write(CFG_WRITE, 9'd255);
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd5);
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd88);
        send_beat(OP_PIXEL, 8'd0);
        send_beat(OP_DRAIN, 8'h00);
        send_beat(OP_DRAIN, 8'h00);
        send_beat(OP_DRAIN, 8'h00);

        // Random frames
        frame_beats = 0;
        phase       = 0;
        regeometry  = 1'b1;
        while (frame_beats < RANDOM_BEATS) begin
            wait_drained();
            quiet = ($urandom_range(0, 4) == 0);
            if (phase == 2 || phase == 7) begin
                // widest and tallest frames, saturated from above; cut short
                // and abandoned to keep the beat count in bounds
                if (phase == 2) begin
                    set_geometry(9'd511, 9'd3);
                    hold_at = geo_cols + 2;
                    set_rule();
                    run_frame(1'b0, geo_cols + 128, geo_cols * geo_rows);
                    hold_at = '1;
                end else begin
                    set_geometry(9'd1, 9'd511);
                    set_rule();
                    run_frame(1'b0, 96, geo_cols * geo_rows);
                end
                regeometry = 1'b1;
            end else begin
                if (regeometry || $urandom_range(0, 2) == 0) pick_small_geometry();
                if ($urandom_range(0, 1) == 0) set_rule();
                total      = geo_cols * geo_rows;
                // an abandoned frame needs a geometry write before the next one
                cut        = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1) : total;
                regeometry = (cut < total);
                rule_at    = ($urandom_range(0, 5) == 0) ? $urandom_range(geo_cols, total - 1)
                                                         : total;
                run_frame(1'b1, cut, rule_at);
            end
            phase++;
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && waiting == 0) begin
            $display("[cross_neighbour_morphology_stencil] OK");
        end else begin
            $display("[cross_neighbour_morphology_stencil] ERROR");
        end
        $finish;
    end

endmodule
